>>> rtl/pf_pkg.sv
`default_nettype none

package pf_pkg;

   localparam int VALUE_PORT_BITS = 32;
   localparam int PRIME_BITS      = 32;
   localparam int EXP_BITS        = 5;
   localparam int STATUS_BITS     = 2;

   localparam logic [STATUS_BITS-1:0] STATUS_FACTOR = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ONE    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPECIAL,
      ST_TWOS,
      ST_CHECK,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic [PRIME_BITS-1:0]  prime_factor;
      logic [EXP_BITS-1:0]    exponent;
      logic                   last;
      logic [STATUS_BITS-1:0] status;
   } result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

>>> rtl/pf_serial_div.sv
`default_nettype none

module pf_serial_div #(
   parameter int WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WIDTH-1:0]     dividend,
   input  wire logic [WIDTH-1:0]     divisor,
   output logic [WIDTH-1:0]          quotient,
   output logic [WIDTH-1:0]          remainder,
   output pf_pkg::div_stat_type      stat
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] quo_in;
   logic [WIDTH-1:0] part_ff;
   logic [WIDTH-1:0] part_in;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             take;

   // one quotient bit per cycle, restoring
   assign trial = {part_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign take  = trial >= {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         part_in = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[WIDTH-2:0], take};
         part_in = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      part_ff <= part_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = part_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("divider busy and done together");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero count");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == CW'(1) && !start |=> done_ff && !busy_ff)
      else $error("divider did not finish on last bit");

endmodule

`default_nettype wire

>>> rtl/prime_factorization_core.sv
`default_nettype none

// Trial-division factorizer. One request is taken at a time while the core is
// idle; it returns one response per distinct prime in ascending order, the
// final one flagged by rsp_last. Zero gives a single response with status 2,
// one a single response with status 1. Factors of two are stripped at one bit
// per cycle; every odd trial divisor then costs one bound check plus, for each
// division, a pass through the bit-serial divider (VALUE_BITS wide, capped at
// 32), and the divider is the pace-setter: a 32-bit prime input needs about
// 32768 divisors, while small or smooth values finish much sooner. Only the
// low VALUE_BITS bits of req_value are factored. A response still waiting in
// the output register stalls the search once the next response is ready.
module prime_factorization_core #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [pf_pkg::VALUE_PORT_BITS-1:0] req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [pf_pkg::PRIME_BITS-1:0]           rsp_prime_factor,
   output logic [pf_pkg::EXP_BITS-1:0]             rsp_exponent,
   output logic                                    rsp_last,
   output logic [pf_pkg::STATUS_BITS-1:0]          rsp_status
);

   localparam int DW = (VALUE_BITS < pf_pkg::VALUE_PORT_BITS) ?
                       VALUE_BITS : pf_pkg::VALUE_PORT_BITS;

   pf_pkg::state_type    state_ff;
   pf_pkg::state_type    state_in;
   logic [DW-1:0]        rem_ff;
   logic [DW-1:0]        rem_in;
   logic [DW-1:0]        d_ff;
   logic [DW-1:0]        d_in;
   logic [DW:0]          sq_ff;
   logic [DW:0]          sq_in;
   logic [pf_pkg::EXP_BITS-1:0] exp_ff;
   logic [pf_pkg::EXP_BITS-1:0] exp_in;
   pf_pkg::result_type   out_ff;
   logic                 out_valid_ff;
   pf_pkg::result_type   res;
   logic                 emit;
   logic                 slot_free;
   logic                 advance;
   logic                 div_start;
   logic [DW-1:0]        div_dividend;
   logic [DW-1:0]        div_quo;
   logic [DW-1:0]        div_rem;
   pf_pkg::div_stat_type div_stat;
   logic [DW-1:0]        value_in;
   logic                 in_bound;

   assign value_in  = req_value[DW-1:0];
   assign in_bound  = sq_ff <= {1'b0, rem_ff};
   assign slot_free = !out_valid_ff || rsp_ready;
   assign advance   = !emit || slot_free;

   pf_serial_div #(
      .WIDTH(DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start && advance),
      .dividend  (div_dividend),
      .divisor   (d_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (value_in <= DW'(1)) ? pf_pkg::ST_SPECIAL : pf_pkg::ST_TWOS;
            end
         end
         pf_pkg::ST_SPECIAL: begin
            state_in = pf_pkg::ST_IDLE;
         end
         pf_pkg::ST_TWOS: begin
            if (rem_ff[0]) begin
               state_in = pf_pkg::ST_CHECK;
            end
         end
         pf_pkg::ST_CHECK: begin
            state_in = in_bound ? pf_pkg::ST_DIV : pf_pkg::ST_IDLE;
         end
         pf_pkg::ST_DIV: begin
            if (div_stat.done && div_rem != '0) begin
               state_in = pf_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = pf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rem_in       = rem_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      div_start    = 1'b0;
      div_dividend = rem_ff;
      emit         = 1'b0;
      res          = '0;
      unique case (state_ff)
         pf_pkg::ST_IDLE: begin
            if (req_valid) begin
               rem_in = value_in;
               exp_in = '0;
            end
         end
         pf_pkg::ST_SPECIAL: begin
            emit       = 1'b1;
            res.last   = 1'b1;
            res.status = rem_ff[0] ? pf_pkg::STATUS_ONE : pf_pkg::STATUS_ZERO;
         end
         pf_pkg::ST_TWOS: begin
            if (!rem_ff[0]) begin
               rem_in = rem_ff >> 1;
               exp_in = exp_ff + pf_pkg::EXP_BITS'(1);
            end else begin
               emit             = exp_ff != '0;
               res.prime_factor = pf_pkg::PRIME_BITS'(2);
               res.exponent     = exp_ff;
               res.last         = rem_ff == DW'(1);
               res.status       = pf_pkg::STATUS_FACTOR;
               d_in             = DW'(3);
               sq_in            = (DW + 1)'(9);
               exp_in           = '0;
            end
         end
         pf_pkg::ST_CHECK: begin
            if (in_bound) begin
               div_start = 1'b1;
            end else begin
               // leftover cofactor is itself prime
               emit             = rem_ff > DW'(1);
               res.prime_factor = pf_pkg::PRIME_BITS'(rem_ff);
               res.exponent     = pf_pkg::EXP_BITS'(1);
               res.last         = 1'b1;
               res.status       = pf_pkg::STATUS_FACTOR;
            end
         end
         pf_pkg::ST_DIV: begin
            if (div_stat.done) begin
               if (div_rem == '0) begin
                  rem_in       = div_quo;
                  exp_in       = exp_ff + pf_pkg::EXP_BITS'(1);
                  div_dividend = div_quo;
                  div_start    = 1'b1;
               end else begin
                  emit             = exp_ff != '0;
                  res.prime_factor = pf_pkg::PRIME_BITS'(d_ff);
                  res.exponent     = exp_ff;
                  res.last         = rem_ff == DW'(1);
                  res.status       = pf_pkg::STATUS_FACTOR;
                  d_in             = d_ff + DW'(2);
                  // (d + 2)^2 = d^2 + 4d + 4
                  sq_in            = sq_ff + (DW + 1)'({d_ff, 2'b00}) + (DW + 1)'(4);
                  exp_in           = '0;
               end
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pf_pkg::ST_IDLE;
         rem_ff       <= '0;
         d_ff         <= '0;
         sq_ff        <= '0;
         exp_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
            rem_ff   <= rem_in;
            d_ff     <= d_in;
            sq_ff    <= sq_in;
            exp_ff   <= exp_in;
         end
         if (emit && slot_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit && slot_free) begin
         out_ff <= res;
      end
   end

   assign req_ready        = state_ff == pf_pkg::ST_IDLE;
   assign rsp_valid        = out_valid_ff;
   assign rsp_prime_factor = out_ff.prime_factor;
   assign rsp_exponent     = out_ff.exponent;
   assign rsp_last         = out_ff.last;
   assign rsp_status       = out_ff.status;

   a_special_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pf_pkg::STATUS_FACTOR |->
         rsp_last && rsp_prime_factor == '0 && rsp_exponent == '0)
      else $error("special response carries factor data");

   a_factor_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pf_pkg::STATUS_FACTOR |-> rsp_exponent != '0)
      else $error("factor response with zero exponent");

   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == pf_pkg::ST_CHECK || state_ff == pf_pkg::ST_DIV |-> d_ff[0])
      else $error("trial divisor is even");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_stat.busy)
      else $error("divider running while idle");

endmodule

`default_nettype wire
